>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the mixer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> hw/rtl/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg
// Types and codes shared by the sample voice mixer modules.
// ----------------------------------------------------------------------------
package svm_pkg;
    typedef enum logic [1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_LENGTH = 2'd1,
        FUNC_START  = 2'd2,
        FUNC_TICK   = 2'd3
    } func_t;

    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // One decoded command between the front and the back.
    typedef struct packed {
        func_t       func;
        logic [3:0]  bank;
        logic [13:0] addr;
        logic [15:0] left;
        logic [15:0] right;
        logic [14:0] blen;
        logic [15:0] gain;
    } cmd_t;
endpackage

>>> hw/rtl/svm_ram.sv
// ----------------------------------------------------------------------------
// svm_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module svm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> hw/rtl/svm_front.sv
// ----------------------------------------------------------------------------
// svm_front
// Input stage and two-entry command queue.
// ----------------------------------------------------------------------------
module svm_front import svm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  cmd_t        in_cmd,
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_cmd
);
    cmd_t       slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = slot_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (in_valid && in_ready) wp_reg <= ~wp_reg;
            if (q_valid && q_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
        end
        if (in_valid && in_ready) slot_reg[wp_reg] <= in_cmd;
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_no_over, aclk, aresetn, cnt_reg == 2'd2, !in_ready)
    `ASSERT_IMPL(a_cnt_rng, aclk, aresetn, 1'b1, cnt_reg != 2'd3)
    `ASSERT_NEXT(a_q_keep, aclk, aresetn, q_valid && !q_ready, q_valid && $stable(q_cmd))
endmodule

>>> hw/rtl/svm_back.sv
// ----------------------------------------------------------------------------
// svm_back
// Executes commands: sample writes, lengths, voice starts and frame mixing.
// ----------------------------------------------------------------------------
module svm_back import svm_pkg::*; #(
    parameter int MAX_VOICES       = 16,
    parameter int NUM_BANKS        = 16,
    parameter int SAMPLES_PER_BANK = 16384
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  cmd_t        q_cmd,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [15:0] m_left,
    output logic [15:0] m_right,
    output logic        m_dropped,
    output logic [4:0]  m_active
);
    localparam int VW  = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int PW  = $clog2(SAMPLES_PER_BANK) + 1;
    localparam int BW  = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int AW  = $clog2(SAMPLES_PER_BANK);
    localparam int MW  = $clog2(NUM_BANKS * (1 << AW));
    localparam int CW  = $clog2(MAX_VOICES + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOOK = 5'b00010,
        ST_READ = 5'b00100,
        ST_ACC  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg;
    logic [VW-1:0] vi_reg;
    logic [MAX_VOICES-1:0] vvalid_reg;
    logic [BW-1:0] vbank_reg [MAX_VOICES];
    logic [PW-1:0] vpos_reg [MAX_VOICES];
    logic [15:0]   vgain_reg [MAX_VOICES];
    logic [PW-1:0] blen_reg [NUM_BANKS];
    logic signed [36:0] lsum_reg, rsum_reg;
    logic play_reg;
    logic signed [32:0] lprod_reg, rprod_reg;
    logic prod_ok_reg;
    logic ov_reg;
    logic okind_reg, odrop_reg;
    logic [15:0] ol_reg, or_reg;
    logic [4:0] oact_reg;

    // Sample memory port.
    logic mem_we;
    logic [MW-1:0] mem_addr;
    logic [31:0] mem_rd;
    svm_ram #(.WIDTH(32), .DEPTH(NUM_BANKS * (1 << AW))) u_mem (
        .aclk(aclk), .we(mem_we), .addr(mem_addr), .wdata({q_cmd.right, q_cmd.left}),
        .rdata(mem_rd)
    );

    logic bank_ok;
    logic [BW-1:0] qbank, cbank;
    logic [PW-1:0] clen, cpos;
    assign bank_ok = ({28'd0, q_cmd.bank} < 32'(NUM_BANKS));
    assign qbank   = q_cmd.bank[BW-1:0];
    assign cbank   = vbank_reg[vi_reg];
    assign clen    = blen_reg[cbank];
    assign cpos    = vpos_reg[vi_reg];

    always_comb begin
        mem_we   = q_ready && q_valid && (q_cmd.func == FUNC_WRITE) && bank_ok
                   && ({18'd0, q_cmd.addr} < 32'(SAMPLES_PER_BANK));
        if (state_reg == ST_IDLE) begin
            mem_addr = MW'({qbank, q_cmd.addr[AW-1:0]});
        end else begin
            mem_addr = MW'({cbank, cpos[AW-1:0]});
        end
    end

    // Lowest free slot and active count over the voice table.
    logic found;
    logic [VW-1:0] free_idx;
    logic [CW-1:0] cnt;
    always_comb begin
        found = 1'b0;
        free_idx = '0;
        cnt = '0;
        for (int i = MAX_VOICES - 1; i >= 0; i--) begin
            if (!vvalid_reg[i]) begin
                found = 1'b1;
                free_idx = VW'(i);
            end
            cnt = cnt + CW'(vvalid_reg[i]);
        end
    end

    function automatic logic [15:0] scale(input logic signed [36:0] s);
        logic neg;
        logic [36:0] mag;
        logic [52:0] q;
        begin
            neg = s[36];
            mag = neg ? 37'(-s) : 37'(s);
            q = (53'(mag) * 53'd32767) >> 30;
            if (neg) scale = (q > 53'd32768) ? 16'h8000 : 16'(-q);
            else scale = (q > 53'd32767) ? 16'h7fff : q[15:0];
        end
    endfunction

    assign q_ready = (state_reg == ST_IDLE) && !ov_reg;
    assign m_valid = ov_reg;
    assign m_kind = okind_reg;
    assign m_left = ol_reg;
    assign m_right = or_reg;
    assign m_dropped = odrop_reg;
    assign m_active = oact_reg;

    logic last_v;
    assign last_v = (vi_reg == VW'(MAX_VOICES - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            vvalid_reg <= '0;
            ov_reg     <= 1'b0;
            vi_reg     <= '0;
            for (int b = 0; b < NUM_BANKS; b++) blen_reg[b] <= '0;
        end else begin
            if (ov_reg && m_ready) ov_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid && !ov_reg) begin
                        case (q_cmd.func)
                            FUNC_LENGTH: begin
                                if (bank_ok) begin
                                    blen_reg[qbank] <= ({17'd0, q_cmd.blen} > 32'(SAMPLES_PER_BANK))
                                        ? PW'(SAMPLES_PER_BANK) : PW'(q_cmd.blen);
                                end
                            end
                            FUNC_START: begin
                                ov_reg    <= 1'b1;
                                okind_reg <= KIND_STATUS;
                                ol_reg    <= '0;
                                or_reg    <= '0;
                                odrop_reg <= !(bank_ok && found);
                                oact_reg  <= 5'(cnt) + 5'(bank_ok && found);
                                if (bank_ok && found) begin
                                    vvalid_reg[free_idx] <= 1'b1;
                                    vbank_reg[free_idx]  <= qbank;
                                    vpos_reg[free_idx]   <= '0;
                                    vgain_reg[free_idx]  <= (q_cmd.gain > 16'd32768)
                                        ? 16'd32768 : q_cmd.gain;
                                end
                            end
                            FUNC_TICK: begin
                                lsum_reg  <= '0;
                                rsum_reg  <= '0;
                                vi_reg    <= '0;
                                state_reg <= ST_LOOK;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_LOOK: begin
                    // Memory address for this voice is presented now.
                    play_reg  <= vvalid_reg[vi_reg] && (cpos < clen);
                    if (vvalid_reg[vi_reg]) begin
                        if (cpos < clen) vpos_reg[vi_reg] <= cpos + PW'(1);
                        if ((cpos < clen ? cpos + PW'(1) : cpos) >= clen)
                            vvalid_reg[vi_reg] <= 1'b0;
                    end
                    state_reg <= ST_READ;
                end
                ST_READ: begin
                    prod_ok_reg <= play_reg;
                    lprod_reg <= $signed(mem_rd[15:0]) * $signed({1'b0, vgain_reg[vi_reg]});
                    rprod_reg <= $signed(mem_rd[31:16]) * $signed({1'b0, vgain_reg[vi_reg]});
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if (prod_ok_reg) begin
                        lsum_reg <= lsum_reg + 37'(lprod_reg);
                        rsum_reg <= rsum_reg + 37'(rprod_reg);
                    end
                    if (last_v) state_reg <= ST_OUT;
                    else begin
                        vi_reg <= vi_reg + VW'(1);
                        state_reg <= ST_LOOK;
                    end
                end
                ST_OUT: begin
                    if (!ov_reg) begin
                        ov_reg    <= 1'b1;
                        okind_reg <= KIND_FRAME;
                        ol_reg    <= scale(lsum_reg);
                        or_reg    <= scale(rsum_reg);
                        odrop_reg <= 1'b0;
                        oact_reg  <= 5'(cnt);
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_busy, aclk, aresetn, state_reg != ST_IDLE, !q_ready)
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_left))
    `ASSERT_IMPL(a_cnt, aclk, aresetn, m_valid, m_active <= 5'(MAX_VOICES))
endmodule

>>> hw/rtl/sample_voice_mixer_core.sv
// ----------------------------------------------------------------------------
// sample_voice_mixer_core
// Stereo sample-playback mixer with a voice table and banked sample memory.
// ----------------------------------------------------------------------------
// channel   dir  tdata                                              tuser
// s_axis    in   bank,addr,left,right,length,loudness (81 -> 88)    func
// m_axis    out  left_out,right_out,start_dropped,active_voices     result_kind
//
// Write, length and start beats are handled without the back end leaving its idle state.
// A frame tick steps through the look, read and accumulate states for each voice table entry,
// then the out state, in a shared read-multiply-accumulate walk over the sample RAM.
// Reset is synchronous; the sample RAM is not cleared.
// A stalled output holds the back end; the input queue absorbs two beats.
`include "assert_macros.svh"
module sample_voice_mixer_core import svm_pkg::*; #(
    parameter int MAX_VOICES       = 16,
    parameter int NUM_BANKS        = 16,
    parameter int SAMPLES_PER_BANK = 16384
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // bank_index, sample_addr, sample_left, sample_right, bank_length, loudness
    input  logic [87:0] s_tdata,
    // func
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // left_out, right_out, start_dropped, active_voices
    output logic [39:0] m_tdata,
    // result_kind
    output logic        m_tuser
);
    cmd_t in_cmd, q_cmd;
    logic q_valid, q_ready;
    logic [15:0] l, r;
    logic d;
    logic [4:0] a;

    assign in_cmd.func  = func_t'(s_tuser);
    assign in_cmd.bank  = s_tdata[3:0];
    assign in_cmd.addr  = s_tdata[17:4];
    assign in_cmd.left  = s_tdata[33:18];
    assign in_cmd.right = s_tdata[49:34];
    assign in_cmd.blen  = s_tdata[64:50];
    assign in_cmd.gain  = s_tdata[80:65];

    svm_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    svm_back #(.MAX_VOICES(MAX_VOICES), .NUM_BANKS(NUM_BANKS),
               .SAMPLES_PER_BANK(SAMPLES_PER_BANK)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_cmd(q_cmd), .m_valid(m_tvalid), .m_ready(m_tready), .m_kind(m_tuser),
        .m_left(l), .m_right(r), .m_dropped(d), .m_active(a)
    );

    assign m_tdata = {2'd0, a, d, r, l};
endmodule

>>> bench/sample_voice_mixer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sample_voice_mixer_core_tb
// Drives sample writes, bank lengths, voice starts and frame ticks into the
// mixer, predicts every frame and start status, and checks each output beat.
// ----------------------------------------------------------------------------
module sample_voice_mixer_core_tb;
    import svm_pkg::*;

    localparam int BANK_WORDS  = 16384;
    localparam int VOICE_SLOTS = 16;
    localparam int IDLE_LIMIT  = 5000;
    localparam int RANDOM_BEATS = 1750;

    typedef struct {
        logic       kind;
        logic [15:0] left;
        logic [15:0] right;
        logic        dropped;
        logic [4:0]  active;
    } mix_out_t;

    typedef struct {
        cmd_t     cmd;
        bit       typed;
        mix_out_t want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic [1:0]  s_tuser = FUNC_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;

    sample_voice_mixer_core dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state.
    logic [31:0] sample_ram [int];
    int          prefix_len [16];
    logic [14:0] bank_len   [16];
    bit          slot_busy  [VOICE_SLOTS];
    logic [3:0]  slot_bank  [VOICE_SLOTS];
    int          slot_pos   [VOICE_SLOTS];
    logic [15:0] slot_gain  [VOICE_SLOTS];

    mix_out_t    pending_mix [$];
    stim_row_t   directed [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          hold_requests = 0;
    bit          sender_fast = 1'b0;

    function automatic logic [15:0] scale_sat(longint acc);
        longint mag;
        longint q;
        mag = (acc < 0) ? -acc : acc;
        q = (mag * 32767) >>> 30;
        if (acc < 0)
            return (q > 32768) ? 16'h8000 : 16'(-q);
        return (q > 32767) ? 16'h7fff : 16'(q);
    endfunction

    function automatic logic [4:0] voices_on();
        int n;
        n = 0;
        for (int i = 0; i < VOICE_SLOTS; i++) n += slot_busy[i];
        return 5'(n);
    endfunction

    // Applies one accepted beat to the predictor; returns 1 when a result follows.
    function automatic bit mix_predict(cmd_t c, output mix_out_t r);
        longint lsum, rsum;
        int     b, len, pos;
        bit     dropped;
        logic [31:0] w;
        lsum = 0;
        rsum = 0;
        r = '{KIND_FRAME, 16'd0, 16'd0, 1'b0, 5'd0};
        case (c.func)
            FUNC_WRITE: begin
                sample_ram[c.bank * BANK_WORDS + c.addr] = {c.right, c.left};
                while (prefix_len[c.bank] < BANK_WORDS &&
                       sample_ram.exists(c.bank * BANK_WORDS + prefix_len[c.bank]))
                    prefix_len[c.bank]++;
                return 1'b0;
            end
            FUNC_LENGTH: begin
                bank_len[c.bank] = (c.blen > 15'd16384) ? 15'd16384 : c.blen;
                return 1'b0;
            end
            FUNC_START: begin
                dropped = 1'b1;
                for (int i = 0; i < VOICE_SLOTS; i++) begin
                    if (dropped && !slot_busy[i]) begin
                        slot_busy[i] = 1'b1;
                        slot_bank[i] = c.bank;
                        slot_pos[i]  = 0;
                        slot_gain[i] = (c.gain > 16'd32768) ? 16'd32768 : c.gain;
                        dropped = 1'b0;
                    end
                end
                r = '{KIND_STATUS, 16'd0, 16'd0, dropped, voices_on()};
                return 1'b1;
            end
            default: begin
                for (int i = 0; i < VOICE_SLOTS; i++) begin
                    if (slot_busy[i]) begin
                        b = slot_bank[i];
                        len = bank_len[b];
                        pos = slot_pos[i];
                        if (pos < len) begin
                            w = sample_ram[b * BANK_WORDS + pos];
                            lsum += longint'($signed(w[15:0])) * longint'(slot_gain[i]);
                            rsum += longint'($signed(w[31:16])) * longint'(slot_gain[i]);
                            pos++;
                            slot_pos[i] = pos;
                        end
                        if (pos >= len) slot_busy[i] = 1'b0;
                    end
                end
                r = '{KIND_FRAME, scale_sat(lsum), scale_sat(rsum), 1'b0, voices_on()};
                return 1'b1;
            end
        endcase
    endfunction

    function automatic cmd_t mk_cmd(func_t f, int bank, int addr, int l, int r,
                                    int blen, int gain);
        cmd_t c;
        c.func = f;
        c.bank = 4'(bank);
        c.addr = 14'(addr);
        c.left = 16'(l);
        c.right = 16'(r);
        c.blen = 15'(blen);
        c.gain = 16'(gain);
        return c;
    endfunction

    function automatic void add_row(cmd_t c, bit typed = 1'b0,
                                    mix_out_t want = '{1'b0, 16'd0, 16'd0, 1'b0, 5'd0});
        directed.insert(directed.size(), '{c, typed, want});
    endfunction

    function automatic cmd_t random_fields();
        cmd_t c;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        c = raw[$bits(cmd_t)-1:0];
        return c;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_beat(cmd_t c, bit typed, mix_out_t want);
        mix_out_t got;
        int gap;
        gap = sender_fast ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, c.gain, c.blen, c.right, c.left, c.addr, c.bank};
        s_tuser  <= c.func;
        do @(posedge aclk); while (!s_tready);
        if (mix_predict(c, got))
            pending_mix.insert(pending_mix.size(), typed ? want : got);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_mix.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic random_beat();
        cmd_t c;
        int p, b, top;
        mix_out_t none;
        none = '{1'b0, 16'd0, 16'd0, 1'b0, 5'd0};
        c = random_fields();
        b = c.bank;
        p = $urandom_range(0, 99);
        if (p < 30) begin
            c.func = FUNC_WRITE;
            if ($urandom_range(0, 19) == 0)
                c.addr = 14'($urandom_range(0, BANK_WORDS - 1));
            else if (prefix_len[b] < 48)
                c.addr = 14'(prefix_len[b]);
            else
                c.addr = 14'($urandom_range(0, prefix_len[b] - 1));
            send_beat(c, 1'b0, none);
        end else if (p < 40) begin
            c.func = FUNC_LENGTH;
            if ($urandom_range(0, 9) == 0) begin
                // An oversized length is fixed up before any tick can read past
                // the written samples.
                top = 32767;
                c.blen = 15'($urandom_range(prefix_len[b] + 1, top));
                send_beat(c, 1'b0, none);
                c = random_fields();
                c.func = FUNC_LENGTH;
                c.bank = 4'(b);
            end
            c.blen = 15'($urandom_range(0, prefix_len[b]));
            send_beat(c, 1'b0, none);
        end else if (p < 62) begin
            c.func = FUNC_START;
            send_beat(c, 1'b0, none);
        end else begin
            c.func = FUNC_TICK;
            send_beat(c, 1'b0, none);
        end
    endtask

    // Sender.
    initial begin
        for (int i = 0; i < 16; i++) begin
            prefix_len[i] = 0;
            bank_len[i] = '0;
        end
        for (int i = 0; i < VOICE_SLOTS; i++) slot_busy[i] = 1'b0;

        add_row(mk_cmd(FUNC_WRITE, 0, 0, 32767, -32768, 0, 0));
        add_row(mk_cmd(FUNC_WRITE, 0, 1, -32768, 32767, 0, 0));
        add_row(mk_cmd(FUNC_LENGTH, 0, 0, 0, 0, 2, 0));
        // Loudness above unity is clipped to unity.
        add_row(mk_cmd(FUNC_START, 0, 0, 0, 0, 0, 65535), 1'b1,
                '{KIND_STATUS, 16'd0, 16'd0, 1'b0, 5'd1});
        add_row(mk_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0), 1'b1,
                '{KIND_FRAME, 16'd32766, 16'h8001, 1'b0, 5'd1});
        // The voice retires on the tick that plays its last sample.
        add_row(mk_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0), 1'b1,
                '{KIND_FRAME, 16'h8001, 16'd32766, 1'b0, 5'd0});
        // A start on a bank of length zero adds nothing and retires on the next tick.
        add_row(mk_cmd(FUNC_START, 15, 0, 0, 0, 0, 8192), 1'b1,
                '{KIND_STATUS, 16'd0, 16'd0, 1'b0, 5'd1});
        add_row(mk_cmd(FUNC_TICK, 15, 0, 0, 0, 0, 0), 1'b1,
                '{KIND_FRAME, 16'd0, 16'd0, 1'b0, 5'd0});
        // Length above the bank size saturates; it is then set back.
        add_row(mk_cmd(FUNC_LENGTH, 0, 0, 0, 0, 32767, 0));
        add_row(mk_cmd(FUNC_LENGTH, 0, 0, 0, 0, 2, 0));
        add_row(mk_cmd(FUNC_WRITE, 1, 16383, -1, 1, 0, 0));
        for (int i = 0; i < VOICE_SLOTS; i++)
            add_row(mk_cmd(FUNC_START, 0, 0, 0, 0, 0, 32768 - i));
        add_row(mk_cmd(FUNC_START, 0, 0, 0, 0, 0, 0), 1'b1,
                '{KIND_STATUS, 16'd0, 16'd0, 1'b1, 5'd16});
        // Sixteen voices at full scale saturate the sum.
        add_row(mk_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_beat(directed[i].cmd, directed[i].typed, directed[i].want);
        drain_results();

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 200 == 0) sender_fast = ($urandom_range(0, 2) == 0);
            if (n == 700) drain_results();
            if (n == 1200) begin
                sender_fast = 1'b1;
                hold_requests++;
            end
            random_beat();
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_mix.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        int seen, hold, stall;
        bit steady;
        seen = 0;
        stall = 0;
        steady = 1'b0;
        forever begin
            @(posedge aclk);
            if (seen != hold_requests) begin
                seen = hold_requests;
                hold = 400;
                m_tready <= 1'b0;
                while (hold > 0) begin
                    @(posedge aclk);
                    hold--;
                end
            end
            if ($urandom_range(0, 299) == 0) steady = !steady;
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                stall = pick_gap();
                m_tready <= (stall == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Output checker.
    always @(posedge aclk) begin
        mix_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_mix.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: kind %0d data %h", m_tuser, m_tdata);
            end else begin
                want = pending_mix.pop_front();
                if (m_tuser !== want.kind || m_tdata[15:0] !== want.left ||
                    m_tdata[31:16] !== want.right || m_tdata[32] !== want.dropped ||
                    m_tdata[37:33] !== want.active) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: want kind %0d L %h R %h drop %0d act %0d",
                                 want.kind, want.left, want.right, want.dropped,
                                 want.active);
                        $display("           got kind %0d L %h R %h drop %0d act %0d",
                                 m_tuser, m_tdata[15:0], m_tdata[31:16],
                                 m_tdata[32], m_tdata[37:33]);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end
endmodule
